@@ hw/rtl/atids_pkg.sv @@
// Shared types and codes for the array table with insert, delete and search.
package atids_pkg;

	localparam int WORD_W = 32;
	localparam int CNT_W  = 6;
	localparam int POS_W  = 5;

	localparam logic [2:0] CMD_SEARCH = 3'd0;
	localparam logic [2:0] CMD_APPEND = 3'd1;
	localparam logic [2:0] CMD_INSERT = 3'd2;
	localparam logic [2:0] CMD_DELETE = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_RANGE    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic [2:0]               command;
		logic signed [WORD_W-1:0] value;
		logic [POS_W-1:0]         position;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic [POS_W-1:0]         found_index;
		logic signed [WORD_W-1:0] read_value;
		logic [CNT_W-1:0]         fill_count;
	} rsp_t;

endpackage

@@ hw/rtl/atids_mem.sv @@
// Entry store: one write port and one registered read port.
module atids_mem import atids_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = rdata_s1;

endmodule

@@ hw/rtl/array_table_insert_delete_search.sv @@
// Array table top level: packed table of signed words with search, append, insert, delete, read.
// One command is worked at a time and req_ready is high only while the sequencer is idle.
// Append, rejected commands and unused codes finish on acceptance; their result goes from the
// result registers to the output register. Search, insert, delete and read walk the entry
// store through its single registered read port, one entry per cycle. Search stops at the
// first match from index 0; insert moves entries up one place from the end down to the
// position, delete moves them down one place from after it. A finished result waits in an
// output register, and a new item is accepted while it waits.
// The capacity register is taken on any cycle (cfg_ready is always high); its effective
// value is limited to DEPTH, and lowering it below the fill count keeps the stored entries.
module array_table_insert_delete_search import atids_pkg::*; #(
	parameter int DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  req_t             req_item,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output rsp_t             rsp_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	localparam int AW = $clog2(DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_DONE} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         cap_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         ptr_q;
	logic [CNT_W-1:0]         rem_q;
	logic [CNT_W-1:0]         lag_q;
	logic                     rv_s1;
	logic [2:0]               cmd_q;
	logic signed [WORD_W-1:0] key_q;
	logic [CNT_W-1:0]         pos_q;
	logic [1:0]               res_status_q;
	logic [POS_W-1:0]         res_found_q;
	logic [WORD_W-1:0]        res_rd_q;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	logic              accept_c;
	logic [CNT_W-1:0]  pos_c;
	logic [CNT_W-1:0]  eff_cap_c;
	logic              we_c;
	logic [CNT_W-1:0]  wa_c;
	logic [WORD_W-1:0] wd_c;
	logic              re_c;
	logic [WORD_W-1:0] rdata;
	logic              fin_c;
	logic [1:0]        fst_c;
	logic [POS_W-1:0]  ffound_c;
	logic [WORD_W-1:0] frd_c;
	logic              cnt_inc_c;
	logic              cnt_dec_c;
	logic              go_walk_c;
	logic [CNT_W-1:0]  init_ptr_c;
	logic [CNT_W-1:0]  init_rem_c;
	logic              load_c;

	assign req_ready = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;
	assign accept_c  = req_valid && req_ready;
	assign pos_c     = {1'b0, req_item.position};
	assign eff_cap_c = (int'(cap_q) > DEPTH) ? CNT_W'(DEPTH) : cap_q;
	assign re_c      = (state_q == S_WALK) && (rem_q != '0);
	assign load_c    = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	atids_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (we_c),
		.waddr (AW'(wa_c)),
		.wdata (wd_c),
		.re    (re_c),
		.raddr (AW'(ptr_q)),
		.rdata (rdata)
	);

	always_comb begin
		we_c       = 1'b0;
		wa_c       = '0;
		wd_c       = '0;
		fin_c      = 1'b0;
		fst_c      = ST_OK;
		ffound_c   = '0;
		frd_c      = '0;
		cnt_inc_c  = 1'b0;
		cnt_dec_c  = 1'b0;
		go_walk_c  = 1'b0;
		init_ptr_c = '0;
		init_rem_c = '0;
		if (state_q == S_IDLE && accept_c) begin
			case (req_item.command)
				CMD_SEARCH: begin
					if (count_q == '0) begin
						fin_c = 1'b1;
						fst_c = ST_NOTFOUND;
					end else begin
						go_walk_c  = 1'b1;
						init_rem_c = count_q;
					end
				end
				CMD_APPEND: begin
					if (count_q >= eff_cap_c) begin
						fin_c = 1'b1;
						fst_c = ST_FULL;
					end else begin
						we_c      = 1'b1;
						wa_c      = count_q;
						wd_c      = req_item.value;
						cnt_inc_c = 1'b1;
						fin_c     = 1'b1;
					end
				end
				CMD_INSERT: begin
					if (pos_c > count_q) begin
						fin_c = 1'b1;
						fst_c = ST_RANGE;
					end else if (count_q >= eff_cap_c) begin
						fin_c = 1'b1;
						fst_c = ST_FULL;
					end else begin
						go_walk_c  = 1'b1;
						init_ptr_c = count_q - CNT_W'(1);
						init_rem_c = count_q - pos_c;
					end
				end
				CMD_DELETE: begin
					if (pos_c >= count_q) begin
						fin_c = 1'b1;
						fst_c = ST_RANGE;
					end else begin
						go_walk_c  = 1'b1;
						init_ptr_c = pos_c + CNT_W'(1);
						init_rem_c = count_q - pos_c - CNT_W'(1);
					end
				end
				CMD_READ: begin
					if (pos_c >= count_q) begin
						fin_c = 1'b1;
						fst_c = ST_RANGE;
					end else begin
						go_walk_c  = 1'b1;
						init_ptr_c = pos_c;
						init_rem_c = CNT_W'(1);
					end
				end
				default: begin
					fin_c = 1'b1;
				end
			endcase
		end else if (state_q == S_WALK) begin
			case (cmd_q)
				CMD_SEARCH: begin
					if (rv_s1 && (rdata == key_q)) begin
						fin_c    = 1'b1;
						ffound_c = lag_q[POS_W-1:0];
					end else if (rv_s1 && (rem_q == '0)) begin
						fin_c = 1'b1;
						fst_c = ST_NOTFOUND;
					end
				end
				CMD_INSERT: begin
					if (rv_s1) begin
						we_c = 1'b1;
						wa_c = lag_q + CNT_W'(1);
						wd_c = rdata;
					end else if (rem_q == '0) begin
						we_c      = 1'b1;
						wa_c      = pos_q;
						wd_c      = key_q;
						cnt_inc_c = 1'b1;
						fin_c     = 1'b1;
					end
				end
				CMD_DELETE: begin
					if (rv_s1) begin
						we_c = 1'b1;
						wa_c = lag_q - CNT_W'(1);
						wd_c = rdata;
					end else if (rem_q == '0) begin
						cnt_dec_c = 1'b1;
						fin_c     = 1'b1;
					end
				end
				CMD_READ: begin
					if (rv_s1) begin
						fin_c = 1'b1;
						frd_c = rdata;
					end
				end
				default: begin
					fin_c = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cap_q        <= CNT_W'(32);
			count_q      <= '0;
			ptr_q        <= '0;
			rem_q        <= '0;
			lag_q        <= '0;
			rv_s1        <= 1'b0;
			cmd_q        <= CMD_SEARCH;
			key_q        <= '0;
			pos_q        <= '0;
			res_status_q <= ST_OK;
			res_found_q  <= '0;
			res_rd_q     <= '0;
			rsp_q        <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			rv_s1 <= re_c;
			if (re_c) begin
				lag_q <= ptr_q;
				rem_q <= rem_q - CNT_W'(1);
				ptr_q <= (cmd_q == CMD_INSERT) ? ptr_q - CNT_W'(1) : ptr_q + CNT_W'(1);
			end
			if (cnt_inc_c) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cnt_dec_c) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept_c) begin
				cmd_q <= req_item.command;
				key_q <= req_item.value;
				pos_q <= pos_c;
			end
			if (go_walk_c) begin
				ptr_q   <= init_ptr_c;
				rem_q   <= init_rem_c;
				state_q <= S_WALK;
			end
			if (fin_c) begin
				res_status_q <= fst_c;
				res_found_q  <= ffound_c;
				res_rd_q     <= frd_c;
				rem_q        <= '0;
				state_q      <= S_DONE;
			end
			if (load_c) begin
				rsp_q.status      <= res_status_q;
				rsp_q.found_index <= res_found_q;
				rsp_q.read_value  <= res_rd_q;
				rsp_q.fill_count  <= count_q;
				rsp_valid_q       <= 1'b1;
				state_q           <= S_IDLE;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q != S_IDLE))
		else $error("accepted item did not start the sequencer");

	a_walk_only: assert property (@(posedge clk) disable iff (!arst_n)
		(rem_q != '0) |-> (state_q == S_WALK))
		else $error("reads pending outside the walk");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1)
			|| count_q == $past(count_q) - CNT_W'(1)))
		else $error("fill count moved by more than one");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(count_q) <= DEPTH)
		else $error("fill count above table depth");

endmodule

@@ test/array_table_insert_delete_search_tb.sv @@
// Self-checking testbench for the array table: directed and random commands, checked in order.
`timescale 1ns / 1ps

module array_table_insert_delete_search_tb;
	import atids_pkg::*;

	localparam int TABLE_DEPTH = 32;
	localparam int DRAIN_CYCLES = 40;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
	localparam logic [CNT_W-1:0] CAP_PLAN [8] = '{6'd32, 6'd1, 6'd63, 6'd0,
		6'd5, 6'd32, 6'd2, 6'd17};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req_item = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp_item;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	logic signed [WORD_W-1:0] table_word [TABLE_DEPTH];
	int table_fill = 0;
	int table_cap = 32;

	req_t pending_cmds [$];
	rsp_t owed_results [$];
	int plan_fill = 0;
	int plan_lim = 32;
	logic signed [WORD_W-1:0] hot_key [8];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;

	array_table_insert_delete_search #(
		.DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_item(rsp_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic rsp_t table_apply(req_t cmd);
		rsp_t res;
		int lim;
		int k;
		res = '0;
		lim = (table_cap > TABLE_DEPTH) ? TABLE_DEPTH : table_cap;
		case (cmd.command)
		CMD_SEARCH: begin
			res.status = ST_NOTFOUND;
			for (k = table_fill - 1; k >= 0; k--) begin
				if (table_word[k] == cmd.value) begin
					res.status = ST_OK;
					res.found_index = POS_W'(k);
				end
			end
		end
		CMD_APPEND: begin
			if (table_fill >= lim) begin
				res.status = ST_FULL;
			end else begin
				table_word[table_fill] = cmd.value;
				table_fill++;
			end
		end
		CMD_INSERT: begin
			if (int'(cmd.position) > table_fill) begin
				res.status = ST_RANGE;
			end else if (table_fill >= lim) begin
				res.status = ST_FULL;
			end else begin
				for (k = table_fill; k > int'(cmd.position); k--)
					table_word[k] = table_word[k - 1];
				table_word[cmd.position] = cmd.value;
				table_fill++;
			end
		end
		CMD_DELETE: begin
			if (int'(cmd.position) >= table_fill) begin
				res.status = ST_RANGE;
			end else begin
				for (k = int'(cmd.position); k + 1 < table_fill; k++)
					table_word[k] = table_word[k + 1];
				table_fill--;
			end
		end
		CMD_READ: begin
			if (int'(cmd.position) >= table_fill)
				res.status = ST_RANGE;
			else
				res.read_value = table_word[cmd.position];
		end
		default: begin
		end
		endcase
		res.fill_count = CNT_W'(table_fill);
		return res;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("%0t ns: %s got %0h want %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// driver
	always @(posedge clk) begin
		if (req_valid && req_ready)
			owed_results.push_back(table_apply(req_item));
		if (!req_valid || req_ready) begin
			if (arst_n && pending_cmds.size() != 0 &&
				int'($urandom_range(0, 99)) >= send_idle_pct) begin
				req_valid <= 1'b1;
				req_item <= pending_cmds.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : watch
		rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (owed_results.size() == 0) begin
				flag_mismatch("result with none owed, status", 32'(rsp_item.status), 32'd0);
			end else begin
				want = owed_results.pop_front();
				if (rsp_item.status !== want.status)
					flag_mismatch("status", 32'(rsp_item.status), 32'(want.status));
				if (rsp_item.found_index !== want.found_index)
					flag_mismatch("found_index", 32'(rsp_item.found_index),
						32'(want.found_index));
				if (rsp_item.read_value !== want.read_value)
					flag_mismatch("read_value", rsp_item.read_value, want.read_value);
				if (rsp_item.fill_count !== want.fill_count)
					flag_mismatch("fill_count", 32'(rsp_item.fill_count),
						32'(want.fill_count));
			end
		end
		rsp_ready <= arst_n && (int'($urandom_range(0, 99)) >= recv_stall_pct);
	end

	task automatic queue_cmd(input logic [2:0] op, input logic signed [WORD_W-1:0] val,
		input logic [POS_W-1:0] pos);
		req_t cmd;
		cmd.command = op;
		cmd.value = val;
		cmd.position = pos;
		pending_cmds.push_back(cmd);
		case (op)
		CMD_APPEND: begin
			if (plan_fill < plan_lim)
				plan_fill++;
		end
		CMD_INSERT: begin
			if (int'(pos) <= plan_fill && plan_fill < plan_lim)
				plan_fill++;
		end
		CMD_DELETE: begin
			if (int'(pos) < plan_fill)
				plan_fill--;
		end
		default: begin
		end
		endcase
	endtask

	task automatic queue_random(input bit grow);
		int roll;
		int pick;
		logic [2:0] op;
		logic signed [WORD_W-1:0] val;
		logic [POS_W-1:0] pos;
		roll = int'($urandom_range(0, 99));
		pick = int'($urandom_range(0, 99));
		val = ($urandom_range(0, 1) != 0) ? hot_key[$urandom_range(0, 7)] : $urandom;
		pos = POS_W'($urandom);
		if (roll < 3) begin
			op = 3'($urandom_range(5, 7));
		end else if (roll < 9) begin
			op = 3'($urandom_range(0, 4));
		end else begin
			if (pick < 20)
				op = CMD_SEARCH;
			else if (pick < 30)
				op = CMD_READ;
			else if (pick < (grow ? 60 : 40))
				op = CMD_APPEND;
			else if (pick < (grow ? 90 : 50))
				op = CMD_INSERT;
			else
				op = CMD_DELETE;
			case (op)
			CMD_SEARCH: begin
				if ($urandom_range(0, 3) != 0)
					val = hot_key[$urandom_range(0, 7)];
			end
			CMD_INSERT: begin
				pos = POS_W'($urandom_range(0, (plan_fill > 31) ? 31 : plan_fill));
			end
			CMD_DELETE, CMD_READ: begin
				pos = (plan_fill == 0) ? '0 : POS_W'($urandom_range(0, plan_fill - 1));
			end
			default: begin
			end
			endcase
		end
		queue_cmd(op, val, pos);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_cmds.size() != 0 || req_valid || owed_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CNT_W-1:0] cap);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= cap;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		table_cap = int'(cap);
		plan_lim = (int'(cap) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cap);
		@(negedge clk);
	endtask

	initial begin
		int ph;
		int n;
		int k;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_capacity(6'd32);

		queue_cmd(CMD_SEARCH, 32'sd0, 5'd0);
		queue_cmd(CMD_READ, 32'sd0, 5'd0);
		queue_cmd(CMD_DELETE, 32'sd0, 5'd0);
		queue_cmd(CMD_INSERT, 32'sd7, 5'd1);
		queue_cmd(CMD_INSERT, WORD_MIN, 5'd0);
		queue_cmd(CMD_APPEND, WORD_MAX, 5'd0);
		queue_cmd(CMD_APPEND, -32'sd1, 5'd0);
		queue_cmd(CMD_INSERT, 32'sd0, 5'd1);
		queue_cmd(CMD_INSERT, 32'sd5, 5'd4);
		queue_cmd(CMD_SEARCH, -32'sd1, 5'd0);
		queue_cmd(CMD_SEARCH, WORD_MAX, 5'd0);
		queue_cmd(CMD_SEARCH, 32'sh1234_5678, 5'd0);
		queue_cmd(CMD_READ, 32'sd0, 5'd0);
		queue_cmd(CMD_READ, 32'sd0, 5'd4);
		queue_cmd(CMD_READ, 32'sd0, 5'd5);
		queue_cmd(CMD_READ, 32'sd0, 5'd31);
		queue_cmd(CMD_APPEND, 32'sd0, 5'd0);
		queue_cmd(CMD_SEARCH, 32'sd0, 5'd0);
		queue_cmd(CMD_DELETE, 32'sd0, 5'd0);
		queue_cmd(CMD_DELETE, 32'sd0, 5'd4);
		queue_cmd(CMD_DELETE, 32'sd0, 5'd31);
		queue_cmd(3'd5, -32'sd1, 5'd31);
		queue_cmd(3'd6, -32'sd1, 5'd31);
		queue_cmd(3'd7, -32'sd1, 5'd31);
		queue_cmd(CMD_INSERT, 32'sd9, 5'd31);
		wait_drained();

		for (ph = 0; ph < 8; ph++) begin
			write_capacity(CAP_PLAN[ph]);
			case (ph % 4)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 67;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 67;
			end
			default: begin
				send_idle_pct = 10;
				recv_stall_pct = 10;
			end
			endcase
			for (k = 0; k < 8; k++)
				hot_key[k] = $urandom;
			hot_key[0] = 32'sd0;
			hot_key[1] = -32'sd1;
			for (n = 0; n < 128; n++) begin
				// hold the sender until every owed result is back
				if (ph == 5 && n == 64)
					wait_drained();
				queue_random(((n / 64) % 2) == 0);
			end
			wait_drained();
		end

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
